[src/analog_key_rapid_trigger_macros.svh]
// Assertion macros shared by the rapid-trigger key checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ANALOG_KEY_RAPID_TRIGGER_MACROS_SVH
`define ANALOG_KEY_RAPID_TRIGGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AKRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rapid trigger key check failed");

// Next-cycle implication, checked outside reset.
`define AKRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rapid trigger key check failed");

`endif

[src/akrt_pkg.sv]
// Shared types and constants of the rapid-trigger analog key block.
// Used by the key update logic, the RAM wrapper users and the top level.
package akrt_pkg;

  localparam int unsigned NUM_SOURCES_DEF = 6;
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned CAL_SAMPLES_DEF = 16;

  localparam int unsigned KEY_W    = 7;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SENS_W   = 10;
  localparam int unsigned DZ_W     = 9;
  localparam int unsigned MASK_W   = 48;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned SUM_W    = 16;

  localparam logic [SENS_W-1:0] SENS_RESET = 10'd50;
  localparam logic [DZ_W-1:0]   DZ_RESET   = 9'd30;
  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  typedef enum logic [1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_DEAD_ZONE   = 2'd1,
    REG_MASK_LOW    = 2'd2,
    REG_MASK_HIGH   = 2'd3
  } akrt_reg_e;

  typedef struct packed {
    logic                cal_done;
    logic [COUNT_W-1:0]  cal_count;
    logic [SUM_W-1:0]    cal_sum;
    logic [SAMPLE_W-1:0] min_lvl;
    logic [SAMPLE_W-1:0] max_lvl;
    logic [SAMPLE_W-1:0] base_level;
    logic                key_on;
  } akrt_entry_t;

  typedef struct packed {
    logic calibrating;
    logic changed;
    logic pressed;
  } akrt_flags_t;

endpackage

[src/akrt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the per-key state entries.
module akrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/akrt_update.sv]
// Per-key state update: baseline calibration and rapid-trigger hysteresis.
// Depends on akrt_pkg for the entry and result flag types.
module akrt_update #(
  parameter int unsigned CAL_SAMPLES = akrt_pkg::CAL_SAMPLES_DEF
) (
  input  akrt_pkg::akrt_entry_t               entry_i,
  input  logic [akrt_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic [akrt_pkg::SENS_W-1:0]         sensitivity_i,
  input  logic [akrt_pkg::DZ_W-1:0]           dead_zone_i,
  output akrt_pkg::akrt_entry_t               entry_o,
  output akrt_pkg::akrt_flags_t               flags_o
);
  import akrt_pkg::*;

  // The sum divided by CAL_SAMPLES is a multiply by a rounded-up reciprocal.
  localparam int unsigned   RECIP_SHIFT = 20;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [35:0]   RECIP       = 36'(RECIP_VAL);

  logic                first_cal;
  logic [SAMPLE_W-1:0] cal_lo;
  logic [SAMPLE_W-1:0] cal_hi;
  logic [SUM_W-1:0]    cal_sum_base;
  logic [SUM_W-1:0]    cal_sum_new;
  logic [COUNT_W-1:0]  cal_count_new;
  logic                cal_finish;
  logic [35:0]         div_prod;
  logic [SAMPLE_W-1:0] cal_base;

  logic [SAMPLE_W-1:0] trg_hi;
  logic [SAMPLE_W-1:0] trg_lo;
  logic [SAMPLE_W-1:0] sens_ext;
  logic [SAMPLE_W:0]   floor_lvl;
  logic [SAMPLE_W+1:0] rel_lvl;
  logic                fell_peak;
  logic                do_release;
  logic                do_press;
  logic                fully_off;
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] diff_adj;
  logic signed [SAMPLE_W:0] diff_step;

  akrt_entry_t e_n;

  assign first_cal     = (entry_i.cal_count == '0);
  assign cal_lo        = first_cal ? sample_i : entry_i.min_lvl;
  assign cal_hi        = first_cal ? sample_i : entry_i.max_lvl;
  assign cal_sum_base  = first_cal ? '0 : entry_i.cal_sum;
  assign cal_sum_new   = cal_sum_base + {{(SUM_W-SAMPLE_W){1'b0}}, sample_i};
  assign cal_count_new = entry_i.cal_count + COUNT_W'(1);
  assign cal_finish    = (cal_count_new >= COUNT_W'(CAL_SAMPLES));
  assign div_prod      = {{(36-SUM_W){1'b0}}, cal_sum_new} * RECIP;
  assign cal_base      = div_prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];

  assign trg_hi    = (sample_i > entry_i.max_lvl) ? sample_i : entry_i.max_lvl;
  assign trg_lo    = (sample_i < entry_i.min_lvl) ? sample_i : entry_i.min_lvl;
  assign sens_ext  = {{(SAMPLE_W-SENS_W){1'b0}}, sensitivity_i};
  assign floor_lvl = {1'b0, entry_i.base_level} + {{(SAMPLE_W+1-DZ_W){1'b0}}, dead_zone_i};
  assign rel_lvl   = {1'b0, floor_lvl}
                   + {{(SAMPLE_W+2-SENS_W+1){1'b0}}, sensitivity_i[SENS_W-1:1]};
  assign fell_peak = (trg_hi < sens_ext) || (sample_i < (trg_hi - sens_ext));
  assign do_release = fell_peak || ({2'b00, sample_i} <= rel_lvl);
  assign do_press  = ({1'b0, sample_i} > ({1'b0, trg_lo} + {1'b0, sens_ext}))
                  && ({1'b0, sample_i} > floor_lvl);
  assign fully_off = ({1'b0, sample_i} <= floor_lvl);
  assign diff      = $signed({1'b0, sample_i}) - $signed({1'b0, entry_i.base_level});
  assign diff_adj  = diff + (diff[SAMPLE_W] ? (SAMPLE_W+1)'(31) : '0);
  assign diff_step = diff_adj >>> 5;

  always_comb begin
    e_n = entry_i;
    if (!entry_i.cal_done) begin
      e_n.min_lvl   = (sample_i < cal_lo) ? sample_i : cal_lo;
      e_n.max_lvl   = (sample_i > cal_hi) ? sample_i : cal_hi;
      e_n.cal_sum   = cal_sum_new;
      e_n.cal_count = cal_count_new;
      if (cal_finish) begin
        e_n.base_level = cal_base;
        e_n.min_lvl    = cal_base;
        e_n.max_lvl    = cal_base;
        e_n.cal_done   = 1'b1;
        e_n.key_on     = 1'b0;
      end
    end else begin
      e_n.max_lvl = trg_hi;
      e_n.min_lvl = trg_lo;
      if (entry_i.key_on) begin
        if (do_release) begin
          e_n.key_on  = 1'b0;
          e_n.min_lvl = sample_i;
          e_n.max_lvl = sample_i;
        end
      end else if (fully_off) begin
        e_n.key_on     = 1'b0;
        e_n.min_lvl    = sample_i;
        e_n.max_lvl    = sample_i;
        e_n.base_level = entry_i.base_level + diff_step[SAMPLE_W-1:0];
      end else if (do_press) begin
        e_n.key_on  = 1'b1;
        e_n.max_lvl = sample_i;
      end
    end
  end

  assign entry_o             = e_n;
  assign flags_o.pressed     = e_n.key_on;
  assign flags_o.changed     = e_n.key_on ^ entry_i.key_on;
  assign flags_o.calibrating = ~e_n.cal_done;

endmodule

[src/analog_key_rapid_trigger.sv]
// Rapid-trigger analog key block. An accepted sample is held in the s1 registers, then its
// result is registered; one sample is accepted every cycle while the output is not stalled.
// Per-key state sits in one RAM with a registered read port; a same-key sample right behind
// another takes the just-written entry from a bypass register.
// Reset loads the default configuration and clears one valid flip-flop per key, so
// every key reads as uncalibrated at once; no clearing pass is needed.
module analog_key_rapid_trigger #(
  parameter int unsigned NUM_SOURCES         = akrt_pkg::NUM_SOURCES_DEF,
  parameter int unsigned CHANNELS_PER_SOURCE = akrt_pkg::CHANNELS_DEF,
  parameter int unsigned CAL_SAMPLES         = akrt_pkg::CAL_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  input  logic [6:0]  s_axis_tuser,   // [2:0] source_sel, [6:3] mux_channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] key_number, [7] pressed, [8] changed,
                                      // [9] calibrating
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i
);
  import akrt_pkg::*;

  localparam int unsigned KEY_SLOTS = NUM_SOURCES * 16;
  localparam int unsigned AW        = $clog2(KEY_SLOTS);
  localparam int unsigned ENTRY_W   = $bits(akrt_entry_t);

  logic [SENS_W-1:0] sens_q;
  logic [DZ_W-1:0]   dz_q;
  logic [MASK_W-1:0] mask_lo_q;
  logic [MASK_W-1:0] mask_hi_q;

  logic [2:0]          in_src;
  logic [3:0]          in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic [KEY_W-1:0]    in_key;
  logic [127:0]        mask_all;
  logic                in_hit;
  logic                in_go;

  logic                s1_valid_q, s1_valid_d;
  logic [KEY_W-1:0]    s1_key_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_vld_q;
  logic                s1_fwd_q;
  logic                s1_adv;
  logic                s1_fire;

  logic [KEY_SLOTS-1:0] valid_q;
  akrt_entry_t          wr_entry_q;
  akrt_entry_t          rd_entry;
  akrt_entry_t          cur_entry;
  akrt_entry_t          new_entry;
  akrt_flags_t          new_flags;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic              out_valid_q, out_valid_d;
  logic [KEY_W-1:0]  out_key_q;
  akrt_flags_t       out_flags_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q    <= SENS_RESET;
      dz_q      <= DZ_RESET;
      mask_lo_q <= MASK_RESET;
      mask_hi_q <= MASK_RESET;
    end else if (cfg_valid_i) begin
      unique case (akrt_reg_e'(cfg_index_i))
        REG_SENSITIVITY: sens_q    <= cfg_wdata_i[SENS_W-1:0];
        REG_DEAD_ZONE:   dz_q      <= cfg_wdata_i[DZ_W-1:0];
        REG_MASK_LOW:    mask_lo_q <= cfg_wdata_i;
        REG_MASK_HIGH:   mask_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_src    = s_axis_tuser[2:0];
  assign in_ch     = s_axis_tuser[6:3];
  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_key    = {in_src, in_ch};
  assign mask_all  = {32'd0, mask_hi_q, mask_lo_q};
  assign in_hit    = ({1'b0, in_src} < 4'(NUM_SOURCES))
                  && ({1'b0, in_ch} < 5'(CHANNELS_PER_SOURCE))
                  && mask_all[in_key];

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && s1_adv;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_go         = s_axis_tvalid && s_axis_tready && in_hit;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = in_go;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        valid_q[s1_key_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      s1_key_q    <= in_key;
      s1_sample_q <= in_sample;
      s1_vld_q    <= valid_q[in_key[AW-1:0]];
      s1_fwd_q    <= s1_fire && (s1_key_q == in_key);
    end
    if (s1_fire) begin
      wr_entry_q  <= new_entry;
      out_key_q   <= s1_key_q;
      out_flags_q <= new_flags;
    end
  end

  akrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_SLOTS)
  ) u_akrt_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_key_q[AW-1:0]),
    .wdata_i (new_entry),
    .re_i    (in_go),
    .raddr_i (in_key[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = akrt_entry_t'(ram_rdata);
  assign cur_entry = s1_fwd_q ? wr_entry_q : (s1_vld_q ? rd_entry : '0);

  akrt_update #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_akrt_update (
    .entry_i       (cur_entry),
    .sample_i      (s1_sample_q),
    .sensitivity_i (sens_q),
    .dead_zone_i   (dz_q),
    .entry_o       (new_entry),
    .flags_o       (new_flags)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_flags_q.calibrating, out_flags_q.changed,
                          out_flags_q.pressed, out_key_q};

endmodule

[src/akrt_checker.sv]
// Port-level checks of the rapid-trigger key block, bound to its top level.
// Depends on analog_key_rapid_trigger_macros.svh for the assertion macros.
`include "analog_key_rapid_trigger_macros.svh"

module akrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result is held unchanged.
  `AKRT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // A key that is still calibrating is never pressed and never toggles.
  `AKRT_ASSERT_IMP(a_cal_idle, m_axis_tvalid && m_axis_tdata[9], !m_axis_tdata[8] && !m_axis_tdata[7])

  // Only a stalled result can hold back the input side.
  `AKRT_ASSERT_IMP(a_ready_free, !m_axis_tvalid, s_axis_tready)

  // Padding bits of a result stay zero.
  `AKRT_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0)

endmodule

bind analog_key_rapid_trigger akrt_checker u_akrt_checker (.*);
